// File: src/brp_pkg.sv
// Shared types and constants for the buffer replacement policy unit.
// No dependencies; every other file imports this package.
package brp_pkg;

	localparam int SLOTS      = 4;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int FILL_W     = $clog2(SLOTS + 1);
	localparam int SLOT_OUT_W = 2;
	localparam int TAG_W      = 16;
	localparam int TIME_W     = 32;
	localparam int CNT_W      = 16;
	localparam int POL_W      = 2;

	localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
	localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
	localparam logic [POL_W-1:0] POL_LFU  = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the requested cluster
		logic exec;   // run lookup, victim pick and slot update
	} brp_cmd_t;

endpackage

// File: src/brp_ctrl.sv
// Controller for the buffer replacement policy unit: request handshake and
// sequencing of the datapath. Depends on brp_pkg.
module brp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output brp_pkg::brp_cmd_t cmd
);
	import brp_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// result registers load on this edge; strobe it
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q == ST_EXEC);
	assign done     = done_q;
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);

endmodule

// File: src/brp_dp.sv
// Datapath for the buffer replacement policy unit: slot table, tag lookup,
// victim search, time and replacement counters, result registers.
// Depends on brp_pkg.
module brp_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brp_pkg::brp_cmd_t              cmd,
	input  logic [brp_pkg::TAG_W-1:0]      cluster,
	input  logic                           cfg_we,
	input  logic [brp_pkg::POL_W-1:0]      cfg_data,
	output logic                           hit,
	output logic [brp_pkg::SLOT_OUT_W-1:0] slot,
	output logic                           evicted,
	output logic [brp_pkg::TAG_W-1:0]      victim_cluster,
	output logic [31:0]                    replacement_total
);
	import brp_pkg::*;

	logic [POL_W-1:0]  policy_q;
	logic [TAG_W-1:0]  req_q;
	logic [TAG_W-1:0]  tag_q   [SLOTS];
	logic [TIME_W-1:0] ltime_q [SLOTS];
	logic [TIME_W-1:0] atime_q [SLOTS];
	logic [CNT_W-1:0]  cnt_q   [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [FILL_W-1:0] fill_q;
	logic [TIME_W-1:0] clock_q;
	logic [31:0]       repl_q;

	logic                  hit_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  evict_q;
	logic [TAG_W-1:0]      victim_q;

	logic [TIME_W-1:0] key      [SLOTS];
	logic [TIME_W-1:0] clock_nx;
	logic [31:0]       repl_nx;
	logic              hit_any;
	logic [SLOT_W-1:0] hit_idx;
	logic [SLOT_W-1:0] vic_idx;
	logic [SLOT_W-1:0] sel;
	logic              full;

	assign clock_nx = (clock_q == '1) ? clock_q : clock_q + TIME_W'(1);
	assign repl_nx  = (repl_q == '1) ? repl_q : repl_q + 32'd1;
	assign full     = (fill_q == FILL_W'(SLOTS));

	// Lowest valid slot whose tag matches
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (valid_q[s] && tag_q[s] == req_q) begin
				hit_any = 1'b1;
				hit_idx = SLOT_W'(s);
			end
		end
	end

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			case (policy_q)
				POL_FIFO: key[s] = ltime_q[s];
				POL_LRU:  key[s] = atime_q[s];
				default:  key[s] = TIME_W'(cnt_q[s]);
			endcase
		end
	end

	// For FIFO, LRU and LFU the smallest key wins, else slot 0; strict compare keeps ties on the lowest slot
	always_comb begin
		vic_idx = '0;
		if (policy_q == POL_FIFO || policy_q == POL_LRU || policy_q == POL_LFU) begin
			for (int s = 1; s < SLOTS; s++) begin
				if (key[s] < key[vic_idx]) begin
					vic_idx = SLOT_W'(s);
				end
			end
		end
	end

	always_comb begin
		if (hit_any) begin
			sel = hit_idx;
		end else if (!full) begin
			sel = fill_q[SLOT_W-1:0];
		end else begin
			sel = vic_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			valid_q  <= '0;
			fill_q   <= '0;
			clock_q  <= '0;
			repl_q   <= '0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_data;
			end
			if (cmd.exec) begin
				clock_q <= clock_nx;
				if (!hit_any) begin
					valid_q[sel] <= 1'b1;
					if (!full) begin
						fill_q <= fill_q + FILL_W'(1);
					end else begin
						repl_q <= repl_nx;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= cluster;
		end
		if (cmd.exec) begin
			if (hit_any) begin
				atime_q[sel] <= clock_nx;
				if (cnt_q[sel] != '1) begin
					cnt_q[sel] <= cnt_q[sel] + CNT_W'(1);
				end
			end else begin
				tag_q[sel]   <= req_q;
				ltime_q[sel] <= clock_nx;
				atime_q[sel] <= clock_nx;
				cnt_q[sel]   <= CNT_W'(1);
			end
			hit_q    <= hit_any;
			slot_q   <= SLOT_OUT_W'(sel);
			evict_q  <= !hit_any && full;
			victim_q <= (!hit_any && full) ? tag_q[sel] : '0;
		end
	end

	assign hit               = hit_q;
	assign slot              = slot_q;
	assign evicted           = evict_q;
	assign victim_cluster    = victim_q;
	// replacement count after the last item; it only moves during exec
	assign replacement_total = repl_q;

endmodule

// File: src/buffer_replacement_policy_unit.sv
// Buffer replacement policy unit: four slots, FIFO/LRU/LFU victim choice.
// done is high in the cycle after the exec cycle; the request is captured in
// the idle state, and the lookup, victim search and slot update run in exec.
// A new request is accepted only in idle, not while the last one is in exec.
// Reset (arst_n, async low) clears valid bits, fill, time and replacement
// counters and policy; the receiver cannot stall, done is high for one cycle
// only and the result outputs hold until the next exec.
module buffer_replacement_policy_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [brp_pkg::TAG_W-1:0]      cluster,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [brp_pkg::POL_W-1:0]      cfg_data,
	output logic                           done,
	output logic                           hit,
	output logic [brp_pkg::SLOT_OUT_W-1:0] slot,
	output logic                           evicted,
	output logic [brp_pkg::TAG_W-1:0]      victim_cluster,
	output logic [31:0]                    replacement_total
);
	import brp_pkg::*;

	brp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	brp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	brp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cluster           (cluster),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.hit               (hit),
		.slot              (slot),
		.evicted           (evicted),
		.victim_cluster    (victim_cluster),
		.replacement_total (replacement_total)
	);

endmodule

// File: src/brp_checker.sv
// Port-level checks for the buffer replacement policy unit, bound to the top.
// Depends on brp_pkg.
module brp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic                      hit,
	input logic                      evicted,
	input logic [brp_pkg::TAG_W-1:0] victim_cluster
);
	import brp_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("result not strobed after busy cycle");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result strobed");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evicted && victim_cluster == '0)
		else $error("hit reported with eviction");

endmodule

bind buffer_replacement_policy_unit brp_checker u_brp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.hit            (hit),
	.evicted        (evicted),
	.victim_cluster (victim_cluster)
);
